@@ sv/mfq_pkg.sv @@
// shared types and constants of the multilevel feedback queue scheduler
// payload structs, command kinds, status codes, register indexes and reset values
package mfq_pkg;

  typedef struct packed {
    logic        mode;
    logic [15:0] job_id;
    logic [15:0] burst_len;
  } mfq_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] served_id;
    logic [2:0]  served_level;
    logic [31:0] wait_time;
    logic [31:0] turnaround_time;
    logic [31:0] jobs_done;
    logic [31:0] wait_sum;
    logic [31:0] turnaround_sum;
    logic [31:0] time_now;
  } mfq_out_t;

  typedef enum logic {
    CMD_ARRIVE = 1'b0,
    CMD_TICK   = 1'b1
  } mfq_kind_t;

  typedef struct packed {
    mfq_kind_t   kind;
    logic [15:0] job_id;
    logic [15:0] burst_len;
  } mfq_cmd_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_DROPPED  = 3'd1,
    ST_IDLE     = 3'd2,
    ST_RUNNING  = 3'd3,
    ST_FINISHED = 3'd4,
    ST_DEMOTED  = 3'd5
  } mfq_status_t;

  localparam logic CFG_LEVEL_COUNT  = 1'b0;
  localparam logic CFG_BASE_QUANTUM = 1'b1;

  localparam logic [2:0]  LEVEL_COUNT_RST  = 3'd5;
  localparam logic [15:0] BASE_QUANTUM_RST = 16'd4;
  localparam int          SLICE_RST        = 4;

endpackage

@@ sv/mfq_ram.sv @@
// generic single write port ram with one registered read port
// no dependencies
module mfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/mfq_front.sv @@
// front end: accepts input items, classifies them into commands and queues them
// uses mfq_pkg
module mfq_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mfq_pkg::mfq_in_t  in_data,
  output logic              cmd_valid,
  output mfq_pkg::mfq_cmd_t cmd,
  input  logic              cmd_take
);
  import mfq_pkg::*;

  mfq_cmd_t   q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  mfq_cmd_t   in_cmd;

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    in_cmd.kind      = in_data.mode ? CMD_TICK : CMD_ARRIVE;
    in_cmd.job_id    = in_data.job_id;
    in_cmd.burst_len = in_data.burst_len;
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = cmd_take ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, cmd_take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

@@ sv/mfq_engine.sv @@
// back end: carries out arrivals and ticks against the level rings and job table
// uses mfq_pkg and mfq_ram
module mfq_engine #(
  parameter int MAX_JOBS   = 64,
  parameter int MAX_LEVELS = 5,
  parameter int TIME_BITS  = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_wdata,
  input  logic              cmd_valid,
  input  mfq_pkg::mfq_cmd_t cmd,
  output logic              cmd_take,
  output logic              out_valid,
  input  logic              out_stall,
  output mfq_pkg::mfq_out_t out_data
);
  import mfq_pkg::*;

  localparam int SLOT_W = $clog2(MAX_JOBS);
  localparam int CNT_W  = $clog2(MAX_JOBS + 1);
  localparam int LVL_W  = $clog2(MAX_LEVELS);
  localparam int RA_W   = $clog2(MAX_LEVELS * MAX_JOBS);
  localparam int JW     = 2 * TIME_BITS + 33;
  localparam int SL_W   = 16 + MAX_LEVELS;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ARR  = 4'b0010,
    S_TKA  = 4'b0100,
    S_TKB  = 4'b1000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [2:0]             level_count_r;
  logic [15:0]            base_r;
  logic [CNT_W-1:0]       count_r [MAX_LEVELS];
  logic [CNT_W-1:0]       count_nxt [MAX_LEVELS];
  logic [SLOT_W-1:0]      head_r [MAX_LEVELS];
  logic [SLOT_W-1:0]      head_nxt [MAX_LEVELS];
  logic [CNT_W-1:0]       fresh_r, fresh_nxt;
  logic [CNT_W-1:0]       sp_r, sp_nxt;
  logic [TIME_BITS-1:0]   tick_r, tick_nxt;
  logic [SL_W-1:0]        slice_r, slice_nxt;
  logic [31:0]            done_r, done_nxt;
  logic [31:0]            wsum_r, wsum_nxt;
  logic [31:0]            tsum_r, tsum_nxt;
  mfq_cmd_t               cmd_r, cmd_nxt;
  logic                   have_r, have_nxt;
  logic [LVL_W-1:0]       lvl_r, lvl_nxt;
  mfq_out_t               res_r, res_nxt;
  logic                   res_valid_r, res_valid_nxt;

  logic                   out_free;
  logic [LVL_W:0]         tl_cur, tl_new;
  logic [3:0]             last;
  logic [15:0]            base_eff;

  logic                   ring_we;
  logic [RA_W-1:0]        ring_waddr, ring_raddr;
  logic [SLOT_W-1:0]      ring_wdata, ring_rdata;
  logic                   job_we;
  logic [SLOT_W-1:0]      job_waddr;
  logic [JW-1:0]          job_wdata, job_rdata;
  logic                   stk_we;
  logic [SLOT_W-1:0]      stk_waddr, stk_raddr, stk_rdata;

  logic [15:0]            j_id, j_work, work_n;
  logic [TIME_BITS-1:0]   j_arr, j_st, start_n;
  logic                   j_started;
  logic [SLOT_W-1:0]      new_slot;
  logic [LVL_W-1:0]       dst_lvl;
  logic [31:0]            wt, tt;

  function automatic logic [LVL_W:0] top_of(input logic [CNT_W-1:0] c [MAX_LEVELS]);
    logic [LVL_W:0] r;
    r = '0;
    for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
      if (c[i] != '0) begin
        r = {1'b1, LVL_W'(i)};
      end
    end
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] tail_of(input logic [SLOT_W-1:0] h,
                                                 input logic [CNT_W-1:0] c);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(h) + (CNT_W + 1)'(c);
    if (s >= (CNT_W + 1)'(MAX_JOBS)) begin
      s = s - (CNT_W + 1)'(MAX_JOBS);
    end
    return SLOT_W'(s);
  endfunction

  function automatic logic [RA_W-1:0] ring_addr(input logic [LVL_W-1:0] l,
                                                input logic [SLOT_W-1:0] idx);
    return RA_W'(RA_W'(l) * RA_W'(MAX_JOBS) + RA_W'(idx));
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? '1 : s[31:0];
  endfunction

  mfq_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_LEVELS * MAX_JOBS)) u_ring (
    .clk(clk), .we(ring_we), .waddr(ring_waddr), .wdata(ring_wdata),
    .raddr(ring_raddr), .rdata(ring_rdata)
  );

  mfq_ram #(.WIDTH(JW), .DEPTH(MAX_JOBS)) u_job (
    .clk(clk), .we(job_we), .waddr(job_waddr), .wdata(job_wdata),
    .raddr(ring_rdata), .rdata(job_rdata)
  );

  // freed slots, used once the never-used slots run out
  mfq_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_JOBS)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(new_slot),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  assign out_valid = res_valid_r;
  assign out_data  = res_r;
  assign out_free  = !res_valid_r || !out_stall;

  assign tl_cur     = top_of(count_r);
  assign ring_raddr = ring_addr(tl_cur[LVL_W-1:0], head_r[tl_cur[LVL_W-1:0]]);
  assign stk_raddr  = SLOT_W'(sp_r - 1'b1);

  assign j_started = job_rdata[0];
  assign j_st      = job_rdata[TIME_BITS:1];
  assign j_arr     = job_rdata[2*TIME_BITS:TIME_BITS+1];
  assign j_work    = job_rdata[2*TIME_BITS+16:2*TIME_BITS+1];
  assign j_id      = job_rdata[JW-1:2*TIME_BITS+17];

  assign base_eff = (base_r == '0) ? 16'd1 : base_r;

  always_comb begin
    if (level_count_r < 3'd2) begin
      last = 4'd1;
    end else if ({1'b0, level_count_r} > 4'(MAX_LEVELS)) begin
      last = 4'(MAX_LEVELS - 1);
    end else begin
      last = {1'b0, level_count_r} - 4'd1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    fresh_nxt     = fresh_r;
    sp_nxt        = sp_r;
    tick_nxt      = tick_r;
    slice_nxt     = slice_r;
    done_nxt      = done_r;
    wsum_nxt      = wsum_r;
    tsum_nxt      = tsum_r;
    cmd_nxt       = cmd_r;
    have_nxt      = have_r;
    lvl_nxt       = lvl_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r && out_stall;
    cmd_take      = 1'b0;
    ring_we       = 1'b0;
    ring_waddr    = '0;
    ring_wdata    = '0;
    job_we        = 1'b0;
    job_waddr     = ring_rdata;
    job_wdata     = '0;
    stk_we        = 1'b0;
    stk_waddr     = SLOT_W'(sp_r);
    new_slot      = ring_rdata;
    dst_lvl       = '0;
    wt            = '0;
    tt            = '0;
    tl_new        = '0;
    start_n       = j_st;
    work_n        = j_work;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_take  = 1'b1;
          cmd_nxt   = cmd;
          have_nxt  = tl_cur[LVL_W];
          lvl_nxt   = tl_cur[LVL_W-1:0];
          state_nxt = (cmd.kind == CMD_TICK) ? S_TKA : S_ARR;
        end
      end
      S_ARR: begin
        if (out_free) begin
          res_nxt        = '0;
          res_nxt.status = ST_ACCEPTED;
          if (fresh_r < CNT_W'(MAX_JOBS)) begin
            new_slot  = SLOT_W'(fresh_r);
            fresh_nxt = fresh_r + 1'b1;
          end else if (sp_r != '0) begin
            new_slot = stk_rdata;
            sp_nxt   = sp_r - 1'b1;
          end else begin
            res_nxt.status = ST_DROPPED;
          end
          if (res_nxt.status == ST_ACCEPTED) begin
            job_we       = 1'b1;
            job_waddr    = new_slot;
            job_wdata    = {cmd_r.job_id, cmd_r.burst_len, tick_r, {TIME_BITS{1'b0}}, 1'b0};
            ring_we      = 1'b1;
            ring_waddr   = ring_addr('0, tail_of(head_r[0], count_r[0]));
            ring_wdata   = new_slot;
            count_nxt[0] = count_r[0] + 1'b1;
          end
          res_nxt.jobs_done      = done_r;
          res_nxt.wait_sum       = wsum_r;
          res_nxt.turnaround_sum = tsum_r;
          res_nxt.time_now       = 32'(tick_r);
          res_valid_nxt          = 1'b1;
          state_nxt              = S_IDLE;
        end
      end
      S_TKA: begin
        state_nxt = S_TKB;
      end
      S_TKB: begin
        if (out_free) begin
          res_nxt = '0;
          if (!have_r) begin
            res_nxt.status = ST_IDLE;
          end else begin
            res_nxt.served_id    = j_id;
            res_nxt.served_level = 3'(lvl_r);
            start_n = j_started ? j_st : tick_r;
            if (j_started && j_work != '0) begin
              work_n = j_work - 1'b1;
            end
            job_we    = 1'b1;
            job_wdata = {j_id, work_n, j_arr, start_n, 1'b1};
            if (work_n == '0) begin
              wt = 32'(TIME_BITS'(start_n - j_arr));
              tt = 32'(TIME_BITS'(tick_r - start_n));
              res_nxt.status          = ST_FINISHED;
              res_nxt.wait_time       = wt;
              res_nxt.turnaround_time = tt;
              done_nxt = sat_add(done_r, 32'd1);
              wsum_nxt = sat_add(wsum_r, wt);
              tsum_nxt = sat_add(tsum_r, tt);
              head_nxt[lvl_r]  = (head_r[lvl_r] == SLOT_W'(MAX_JOBS - 1)) ? '0
                                 : head_r[lvl_r] + 1'b1;
              count_nxt[lvl_r] = count_r[lvl_r] - 1'b1;
              stk_we = 1'b1;
              sp_nxt = sp_r + 1'b1;
              tl_new    = top_of(count_nxt);
              slice_nxt = SL_W'(base_eff) << tl_new[LVL_W-1:0];
            end else if (4'(lvl_r) < last && slice_r == '0) begin
              // demote: work done this tick, then move to the next level's tail
              dst_lvl            = LVL_W'(lvl_r + 1'b1);
              res_nxt.status     = ST_DEMOTED;
              head_nxt[lvl_r]    = (head_r[lvl_r] == SLOT_W'(MAX_JOBS - 1)) ? '0
                                   : head_r[lvl_r] + 1'b1;
              count_nxt[lvl_r]   = count_r[lvl_r] - 1'b1;
              ring_we            = 1'b1;
              ring_waddr         = ring_addr(dst_lvl, tail_of(head_r[dst_lvl],
                                                              count_r[dst_lvl]));
              ring_wdata         = ring_rdata;
              count_nxt[dst_lvl] = count_r[dst_lvl] + 1'b1;
              tl_new    = top_of(count_nxt);
              slice_nxt = SL_W'(base_eff) << tl_new[LVL_W-1:0];
            end else begin
              res_nxt.status = ST_RUNNING;
              if (slice_r != '0) begin
                slice_nxt = slice_r - 1'b1;
              end
            end
          end
          res_nxt.jobs_done      = done_nxt;
          res_nxt.wait_sum       = wsum_nxt;
          res_nxt.turnaround_sum = tsum_nxt;
          res_nxt.time_now       = 32'(tick_r);
          tick_nxt               = tick_r + 1'b1;
          res_valid_nxt          = 1'b1;
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      level_count_r <= LEVEL_COUNT_RST;
      base_r        <= BASE_QUANTUM_RST;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        count_r[i] <= '0;
        head_r[i]  <= '0;
      end
      fresh_r     <= '0;
      sp_r        <= '0;
      tick_r      <= '0;
      slice_r     <= SL_W'(SLICE_RST);
      done_r      <= '0;
      wsum_r      <= '0;
      tsum_r      <= '0;
      have_r      <= 1'b0;
      lvl_r       <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      fresh_r     <= fresh_nxt;
      sp_r        <= sp_nxt;
      tick_r      <= tick_nxt;
      slice_r     <= slice_nxt;
      done_r      <= done_nxt;
      wsum_r      <= wsum_nxt;
      tsum_r      <= tsum_nxt;
      have_r      <= have_nxt;
      lvl_r       <= lvl_nxt;
      res_valid_r <= res_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LEVEL_COUNT:  level_count_r <= cfg_wdata[2:0];
          CFG_BASE_QUANTUM: base_r        <= cfg_wdata;
          default: ;
        endcase
      end
    end
    cmd_r <= cmd_nxt;
    res_r <= res_nxt;
  end

endmodule

@@ sv/multilevel_feedback_queue_scheduler.sv @@
// top level of the multilevel feedback queue scheduler
// uses mfq_pkg, mfq_front and mfq_engine
//
// Items enter through a two-entry command queue, so up to two items are taken
// while the scheduler core works. The core handles one command at a time: an
// arrival goes through dispatch, then slot allocation and ring write; a tick
// goes through dispatch with the level ring read, the job table read, then
// update and write-back, an order set by the chained registered reads of the
// ring memory and the job table. Every item gives exactly one result, held in
// an output register; the core waits in its last state while that register is
// stalled. No clearing pass is needed after reset.
module multilevel_feedback_queue_scheduler #(
  parameter int MAX_JOBS   = 64,
  parameter int MAX_LEVELS = 5,
  parameter int TIME_BITS  = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mfq_pkg::mfq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mfq_pkg::mfq_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_wdata
);
  import mfq_pkg::*;

  logic     cmd_valid;
  logic     cmd_take;
  mfq_cmd_t cmd;

  mfq_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
  );

  mfq_engine #(
    .MAX_JOBS(MAX_JOBS), .MAX_LEVELS(MAX_LEVELS), .TIME_BITS(TIME_BITS)
  ) u_engine (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule

@@ tb/sv/tb_multilevel_feedback_queue_scheduler.sv @@
// self-checking testbench of the multilevel feedback queue scheduler
// depends on mfq_pkg and multilevel_feedback_queue_scheduler; predicts every result
`timescale 1ns / 100ps

module tb_multilevel_feedback_queue_scheduler;
  import mfq_pkg::*;

  localparam int NJOBS   = 64;
  localparam int NLVL    = 5;
  localparam int LIMIT   = 600000;
  localparam int HOLD_CY = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  mfq_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  mfq_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_LEVEL_COUNT;
  logic [15:0] cfg_wdata = '0;

  multilevel_feedback_queue_scheduler i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .cfg_we, .cfg_index, .cfg_wdata
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // scheduler shadow state
  logic [2:0]      lvl_cfg = LEVEL_COUNT_RST;
  logic [15:0]     quantum_cfg = BASE_QUANTUM_RST;
  logic [15:0]     job_tag [NJOBS];
  logic [15:0]     job_work [NJOBS];
  logic [31:0]     job_arrival [NJOBS];
  logic [31:0]     job_begin [NJOBS];
  bit              job_begun [NJOBS];
  bit              slot_busy [NJOBS];
  int              level_q [NLVL][$];
  longint unsigned slice_cnt = SLICE_RST;
  logic [31:0]     now_ticks = '0;
  logic [31:0]     done_cnt = '0, wait_total = '0, turn_total = '0;

  mfq_in_t  pending_q [$];
  mfq_out_t expected_q [$];
  int       errors = 0;
  int       send_idle_pct = 0, recv_idle_pct = 0;
  int       n_arrive = 0, n_drop = 0, n_idle = 0, n_fin = 0, n_demote = 0, n_run = 0;
  int       cycles = 0;
  bit       hold_req = 1'b0, hold_taken = 1'b0;
  int       hold_left = 0;

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic int first_busy_level();
    int l;
    l = -1;
    for (int i = NLVL - 1; i >= 0; i--)
      if (level_q[i].size() != 0) l = i;
    return l;
  endfunction

  task automatic reload_slice();
    int l;
    longint unsigned b;
    l = first_busy_level();
    b = (quantum_cfg == 0) ? 1 : quantum_cfg;
    if (l < 0) l = 0;
    slice_cnt = b << l;
  endtask

  task automatic schedule_item(input mfq_in_t it);
    mfq_out_t r;
    int       last_lvl, lvl, slot;
    r = '0;
    r.time_now = now_ticks;
    last_lvl = (lvl_cfg < 2) ? 2 : ((lvl_cfg > NLVL) ? NLVL : lvl_cfg);
    last_lvl--;
    if (mfq_kind_t'(it.mode) == CMD_ARRIVE) begin
      slot = -1;
      for (int s = NJOBS - 1; s >= 0; s--)
        if (!slot_busy[s]) slot = s;
      if (slot < 0) begin
        r.status = ST_DROPPED;
        n_drop++;
      end else begin
        slot_busy[slot] = 1'b1;
        job_tag[slot] = it.job_id;
        job_work[slot] = it.burst_len;
        job_arrival[slot] = now_ticks;
        job_begin[slot] = '0;
        job_begun[slot] = 1'b0;
        level_q[0].push_back(slot);
        r.status = ST_ACCEPTED;
        n_arrive++;
      end
    end else begin
      lvl = first_busy_level();
      if (lvl < 0) begin
        r.status = ST_IDLE;
        n_idle++;
      end else begin
        slot = level_q[lvl][0];
        r.served_id = job_tag[slot];
        r.served_level = lvl[2:0];
        if (!job_begun[slot]) begin
          job_begun[slot] = 1'b1;
          job_begin[slot] = now_ticks;
        end else if (job_work[slot] != 0) begin
          job_work[slot]--;
        end
        if (job_work[slot] == 0) begin
          r.wait_time = job_begin[slot] - job_arrival[slot];
          r.turnaround_time = now_ticks - job_begin[slot];
          done_cnt = sat_sum(done_cnt, 32'd1);
          wait_total = sat_sum(wait_total, r.wait_time);
          turn_total = sat_sum(turn_total, r.turnaround_time);
          void'(level_q[lvl].pop_front());
          slot_busy[slot] = 1'b0;
          reload_slice();
          r.status = ST_FINISHED;
          n_fin++;
        end else if (lvl < last_lvl && slice_cnt == 0) begin
          level_q[lvl + 1].push_back(level_q[lvl].pop_front());
          reload_slice();
          r.status = ST_DEMOTED;
          n_demote++;
        end else begin
          if (slice_cnt != 0) slice_cnt--;
          r.status = ST_RUNNING;
          n_run++;
        end
      end
      now_ticks++;
    end
    r.jobs_done = done_cnt;
    r.wait_sum = wait_total;
    r.turnaround_sum = turn_total;
    expected_q.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // input driver; the prediction runs on each accepted transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) schedule_item(in_data);
      if (!in_valid || !in_stall) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold, counted here
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_left <= HOLD_CY;
      hold_taken <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    mfq_out_t w;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", out_data.status, '0);
        end else begin
          w = expected_q.pop_front();
          if (out_data.status !== w.status)
            report_mismatch("status", out_data.status, w.status);
          if (out_data.served_id !== w.served_id)
            report_mismatch("served_id", out_data.served_id, w.served_id);
          if (out_data.served_level !== w.served_level)
            report_mismatch("served_level", out_data.served_level, w.served_level);
          if (out_data.wait_time !== w.wait_time)
            report_mismatch("wait_time", out_data.wait_time, w.wait_time);
          if (out_data.turnaround_time !== w.turnaround_time)
            report_mismatch("turnaround_time", out_data.turnaround_time,
                            w.turnaround_time);
          if (out_data.jobs_done !== w.jobs_done)
            report_mismatch("jobs_done", out_data.jobs_done, w.jobs_done);
          if (out_data.wait_sum !== w.wait_sum)
            report_mismatch("wait_sum", out_data.wait_sum, w.wait_sum);
          if (out_data.turnaround_sum !== w.turnaround_sum)
            report_mismatch("turnaround_sum", out_data.turnaround_sum, w.turnaround_sum);
          if (out_data.time_now !== w.time_now)
            report_mismatch("time_now", out_data.time_now, w.time_now);
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic mfq_in_t make_item(mfq_kind_t k, logic [15:0] id, logic [15:0] len);
    mfq_in_t it;
    it.mode = k;
    it.job_id = id;
    it.burst_len = len;
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_regs(input logic [2:0] lc, input logic [15:0] bq);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_LEVEL_COUNT;
    cfg_wdata <= {13'd0, lc};
    @(posedge clk);
    cfg_index <= CFG_BASE_QUANTUM;
    cfg_wdata <= bq;
    @(posedge clk);
    cfg_we <= 1'b0;
    lvl_cfg = lc;
    quantum_cfg = bq;
  endtask

  task automatic queue_random(input int n, input int arrive_pct);
    int          p;
    logic [15:0] len;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < arrive_pct) begin
        p = $urandom_range(99);
        if (p < 3) len = 16'($urandom_range(65535));
        else if (p < 15) len = '0;
        else len = 16'($urandom_range(12, 1));
        pending_q.push_back(make_item(CMD_ARRIVE, 16'($urandom_range(65535)), len));
      end else begin
        // tick items carry junk in the unused fields
        pending_q.push_back(make_item(CMD_TICK, 16'($urandom_range(65535)),
                                      16'($urandom_range(65535))));
      end
    end
  endtask

  logic [2:0]  lc_set [7] = '{3'd2, 3'd0, 3'd7, 3'd3, 3'd1, 3'd4, 3'd5};
  logic [15:0] bq_set [7] = '{16'd1, 16'd0, 16'd65535, 16'd2, 16'd3, 16'd1, 16'd4};
  int          arr_set [7] = '{90, 40, 55, 90, 45, 55, 40};

  initial begin
    for (int s = 0; s < NJOBS; s++) slot_busy[s] = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    write_regs(LEVEL_COUNT_RST, BASE_QUANTUM_RST);

    // directed: idle tick, field extremes, zero burst, demotion, endless job
    pending_q.push_back(make_item(CMD_TICK, 16'hFFFF, 16'hFFFF));
    pending_q.push_back(make_item(CMD_ARRIVE, 16'hFFFF, 16'd0));
    pending_q.push_back(make_item(CMD_ARRIVE, 16'd0, 16'd1));
    pending_q.push_back(make_item(CMD_ARRIVE, 16'h1234, 16'd20));
    pending_q.push_back(make_item(CMD_ARRIVE, 16'hABCD, 16'hFFFF));
    for (int i = 0; i < 19; i++)
      pending_q.push_back(make_item(CMD_TICK, 16'd0, 16'd0));
    wait_drained();

    for (int ph = 0; ph < 7; ph++) begin
      write_regs(lc_set[ph], bq_set[ph]);
      send_idle_pct = (ph < 2) ? 34 : ((ph < 4) ? 79 : 0);
      recv_idle_pct = (ph < 2) ? 79 : ((ph < 4) ? 34 : 0);
      if (ph == 4) hold_req = 1'b1;
      queue_random(175, arr_set[ph]);
      wait_drained();
    end

    $display("%0d arrivals, %0d dropped, %0d idle ticks, %0d runs, %0d demotions,",
             n_arrive, n_drop, n_idle, n_run, n_demote);
    $display("%0d finished jobs over %0d ticks and seven register settings",
             n_fin, now_ticks);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
